FILE: design/cvm_pkg.sv
// Shared types and constants for the camera view matrix builder.
// No dependencies; every other file of the block takes names from here.
package cvm_pkg;

  localparam int WORD_W      = 32;
  // Greedy alignment steps: shift amounts 16, 8, 4, 2, 1, then a final one-bit step.
  localparam int ALIGN_STEPS = 5;
  // One root bit per stage of the square root pipeline.
  localparam int SQRT_STEPS  = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // Normalizer latency: magnitude, alignment, final align, square, sum,
  // square root, divider set-up, FRAC_BITS+1 quotient bits, sign.
  function automatic int norm_lat(input int frac_bits);
    return ALIGN_STEPS + SQRT_STEPS + frac_bits + 7;
  endfunction

endpackage

FILE: design/cvm_ifs.sv
// Valid/ready channel interfaces for the camera view matrix builder.
// Depends on cvm_pkg for the word type.
interface cvm_in_if;
  logic           valid;
  logic           ready;
  cvm_pkg::word_t pos_x;
  cvm_pkg::word_t pos_y;
  cvm_pkg::word_t pos_z;
  cvm_pkg::word_t right_in_x;
  cvm_pkg::word_t right_in_y;
  cvm_pkg::word_t right_in_z;
  cvm_pkg::word_t look_in_x;
  cvm_pkg::word_t look_in_y;
  cvm_pkg::word_t look_in_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, right_in_x, right_in_y, right_in_z,
           look_in_x, look_in_y, look_in_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, right_in_x, right_in_y, right_in_z,
           look_in_x, look_in_y, look_in_z,
    output ready
  );
endinterface

interface cvm_out_if;
  logic           valid;
  logic           ready;
  cvm_pkg::word_t right_x;
  cvm_pkg::word_t right_y;
  cvm_pkg::word_t right_z;
  cvm_pkg::word_t up_x;
  cvm_pkg::word_t up_y;
  cvm_pkg::word_t up_z;
  cvm_pkg::word_t look_x;
  cvm_pkg::word_t look_y;
  cvm_pkg::word_t look_z;
  cvm_pkg::word_t trans_x;
  cvm_pkg::word_t trans_y;
  cvm_pkg::word_t trans_z;

  modport source (
    output valid, right_x, right_y, right_z, up_x, up_y, up_z,
           look_x, look_y, look_z, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, right_x, right_y, right_z, up_x, up_y, up_z,
           look_x, look_y, look_z, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

FILE: design/cvm_norm.sv
// Pipelined 3-vector normalizer: align, sum of squares, square root, divide.
// Depends on cvm_pkg, whose norm_lat sums its stages; one vector per cycle while en is high.
module cvm_norm #(
  parameter int IW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_c [3],
  output logic                 out_valid,
  output cvm_pkg::word_t       out_n [3]
);

  localparam int AS   = cvm_pkg::ALIGN_STEPS;
  localparam int SS   = cvm_pkg::SQRT_STEPS;
  localparam int WW   = cvm_pkg::WORD_W;
  localparam int SQW  = 2 * SS;
  localparam int DS   = FRAC_BITS + 1;
  localparam int QW   = FRAC_BITS + 1;
  localparam int RW   = WW + FRAC_BITS;
  localparam logic [63:0] HI_LIM = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LO_LIM = 64'h0000_0000_4000_0000;

  // Magnitude and alignment stages
  logic [IW-1:0] mag_nxt [3];
  logic [IW-1:0] mx_nxt;
  logic [2:0]    neg_nxt;

  logic          al_v_r   [0:AS];
  logic [IW-1:0] al_m_r   [0:AS][3];
  logic [IW-1:0] al_mx_r  [0:AS];
  logic [2:0]    al_neg_r [0:AS];

  always_comb begin
    mx_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = in_c[i][IW-1] ? $unsigned(-in_c[i]) : $unsigned(in_c[i]);
      neg_nxt[i] = in_c[i][IW-1];
      if (mag_nxt[i] > mx_nxt) mx_nxt = mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      al_v_r[0] <= 1'b0;
    end else if (en) begin
      al_v_r[0] <= in_valid;
    end
    if (en) begin
      al_m_r[0]   <= mag_nxt;
      al_mx_r[0]  <= mx_nxt;
      al_neg_r[0] <= neg_nxt;
    end
  end

  for (genvar k = 0; k < AS; k++) begin : g_align
    localparam int A = 1 << (AS - 1 - k);
    logic [63:0] mxw;
    logic        rsh;
    logic        lsh;

    always_comb begin
      mxw = 64'(al_mx_r[k]);
      rsh = (mxw >> A) > HI_LIM;
      lsh = mxw < (LO_LIM >> A);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        al_v_r[k+1] <= 1'b0;
      end else if (en) begin
        al_v_r[k+1] <= al_v_r[k];
      end
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          al_m_r[k+1][i] <= rsh ? (al_m_r[k][i] >> A) :
                            lsh ? (al_m_r[k][i] << A) : al_m_r[k][i];
        end
        al_mx_r[k+1]  <= rsh ? (al_mx_r[k] >> A) :
                         lsh ? (al_mx_r[k] << A) : al_mx_r[k];
        al_neg_r[k+1] <= al_neg_r[k];
      end
    end
  end

  // Final one-bit alignment; magnitudes now fit in a word
  logic [63:0]   fmxw;
  logic          frsh;
  logic          flsh;
  logic          fn_v_r;
  logic [WW-1:0] fn_m_r [3];
  logic [2:0]    fn_neg_r;

  always_comb begin
    fmxw = 64'(al_mx_r[AS]);
    frsh = fmxw > HI_LIM;
    flsh = fmxw < LO_LIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_v_r <= 1'b0;
    end else if (en) begin
      fn_v_r <= al_v_r[AS];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fn_m_r[i] <= WW'(frsh ? (al_m_r[AS][i] >> 1) :
                         flsh ? (al_m_r[AS][i] << 1) : al_m_r[AS][i]);
      end
      fn_neg_r <= al_neg_r[AS];
    end
  end

  // Squares, then their sum
  logic           sqr_v_r;
  logic [SQW-1:0] sqr_r   [3];
  logic [WW-1:0]  sqr_m_r [3];
  logic [2:0]     sqr_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_v_r <= 1'b0;
    end else if (en) begin
      sqr_v_r <= fn_v_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqr_r[i] <= fn_m_r[i] * fn_m_r[i];
      end
      sqr_m_r   <= fn_m_r;
      sqr_neg_r <= fn_neg_r;
    end
  end

  logic           sq_v_r    [0:SS];
  logic [SQW-1:0] sq_rem_r  [0:SS];
  logic [SS-1:0]  sq_root_r [0:SS];
  logic [WW-1:0]  sq_m_r    [0:SS][3];
  logic [2:0]     sq_neg_r  [0:SS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= sqr_v_r;
    end
    if (en) begin
      sq_rem_r[0]  <= sqr_r[0] + sqr_r[1] + sqr_r[2];
      sq_root_r[0] <= '0;
      sq_m_r[0]    <= sqr_m_r;
      sq_neg_r[0]  <= sqr_neg_r;
    end
  end

  // Square root, one root bit per stage, remainder form
  for (genvar j = 0; j < SS; j++) begin : g_sqrt
    localparam int B = SS - 1 - j;
    logic [SQW+1:0] trial;
    logic           take;

    always_comb begin
      trial = ((SQW+2)'(sq_root_r[j]) << (B + 1)) | ((SQW+2)'(1) << (2 * B));
      take  = (SQW+2)'(sq_rem_r[j]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
      if (en) begin
        sq_rem_r[j+1]  <= take ? SQW'((SQW+2)'(sq_rem_r[j]) - trial) : sq_rem_r[j];
        sq_root_r[j+1] <= take ? (sq_root_r[j] | (SS'(1) << B)) : sq_root_r[j];
        sq_m_r[j+1]    <= sq_m_r[j];
        sq_neg_r[j+1]  <= sq_neg_r[j];
      end
    end
  end

  // Divider set-up and restoring division, one quotient bit per stage
  logic          dv_v_r   [0:DS];
  logic [RW-1:0] dv_rem_r [0:DS][3];
  logic [QW-1:0] dv_q_r   [0:DS][3];
  logic [SS-1:0] dv_len_r [0:DS];
  logic [2:0]    dv_neg_r [0:DS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SS];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= RW'(sq_m_r[SS][i]) << FRAC_BITS;
        dv_q_r[0][i]   <= '0;
      end
      // a zero length only comes with an all-zero vector
      dv_len_r[0] <= (sq_root_r[SS] == '0) ? SS'(1) : sq_root_r[SS];
      dv_neg_r[0] <= sq_neg_r[SS];
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int B = FRAC_BITS - j;
    logic [RW-1:0] sub;
    logic [2:0]    take;

    always_comb begin
      sub = RW'(dv_len_r[j]) << B;
      for (int i = 0; i < 3; i++) begin
        take[i] = dv_rem_r[j][i] >= sub;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j+1][i] <= take[i] ? (dv_rem_r[j][i] - sub) : dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= take[i] ? (dv_q_r[j][i] | (QW'(1) << B)) : dv_q_r[j][i];
        end
        dv_len_r[j+1] <= dv_len_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
      end
    end
  end

  // Restore the sign
  logic           sg_v_r;
  cvm_pkg::word_t sg_n_r [3];
  cvm_pkg::word_t qx     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = cvm_pkg::word_t'(WW'(dv_q_r[DS][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_v_r <= 1'b0;
    end else if (en) begin
      sg_v_r <= dv_v_r[DS];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sg_n_r[i] <= dv_neg_r[DS][i] ? -qx[i] : qx[i];
      end
    end
  end

  assign out_valid = sg_v_r;
  assign out_n     = sg_n_r;

endmodule

FILE: design/camera_view_matrix_builder.sv
// Camera view matrix builder: orthonormal right/up/look axes and translation row.
// The two normalizers make up most of the pipeline depth (Q16.16 by default, FRAC_BITS = 16).
// Throughput: one beat per cycle; every stage holds while a finished beat waits.
// Reset (synchronous, active low) clears all valid bits; payload registers keep data.
// Depends on cvm_pkg, cvm_ifs (channel interfaces) and cvm_norm.
module camera_view_matrix_builder #(
  parameter int FRAC_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  cvm_in_if.sink   in_ch,
  cvm_out_if.source out_ch
);

  localparam int NL = cvm_pkg::norm_lat(FRAC_BITS);
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] S_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S_MIN = -64'sd2147483648;
  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;

  // Global advance: the whole pipeline moves unless the output beat is stuck.
  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------------
  // Normalize look
  // ---------------------------------------------------------------------------
  logic signed [31:0] look_in [3];
  logic               n1_v;
  cvm_pkg::word_t     lk      [3];

  assign look_in[0] = in_ch.look_in_x;
  assign look_in[1] = in_ch.look_in_y;
  assign look_in[2] = in_ch.look_in_z;

  cvm_norm #(
    .IW        (32),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_look (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_c      (look_in),
    .out_valid (n1_v),
    .out_n     (lk)
  );

  // Carry position and right alongside the look normalizer.
  cvm_pkg::word_t pa_r [0:NL-1][3];
  cvm_pkg::word_t ra_r [0:NL-1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0][0] <= in_ch.pos_x;
      pa_r[0][1] <= in_ch.pos_y;
      pa_r[0][2] <= in_ch.pos_z;
      ra_r[0][0] <= in_ch.right_in_x;
      ra_r[0][1] <= in_ch.right_in_y;
      ra_r[0][2] <= in_ch.right_in_z;
      for (int k = 1; k < NL; k++) begin
        pa_r[k] <= pa_r[k-1];
        ra_r[k] <= ra_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Cross look x right, exact products
  // ---------------------------------------------------------------------------
  logic               x1_v_r;
  logic signed [63:0] x1_prod_r [6];
  cvm_pkg::word_t     x1_p_r    [3];
  cvm_pkg::word_t     x1_lk_r   [3];
  logic               x2_v_r;
  logic signed [63:0] x2_c_r    [3];
  cvm_pkg::word_t     x2_p_r    [3];
  cvm_pkg::word_t     x2_lk_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
    end else if (en) begin
      x1_v_r <= n1_v;
      x2_v_r <= x1_v_r;
    end
    if (en) begin
      x1_prod_r[0] <= lk[1] * ra_r[NL-1][2];
      x1_prod_r[1] <= lk[2] * ra_r[NL-1][1];
      x1_prod_r[2] <= lk[2] * ra_r[NL-1][0];
      x1_prod_r[3] <= lk[0] * ra_r[NL-1][2];
      x1_prod_r[4] <= lk[0] * ra_r[NL-1][1];
      x1_prod_r[5] <= lk[1] * ra_r[NL-1][0];
      x1_p_r       <= pa_r[NL-1];
      x1_lk_r      <= lk;
      x2_c_r[0]    <= x1_prod_r[0] - x1_prod_r[1];
      x2_c_r[1]    <= x1_prod_r[2] - x1_prod_r[3];
      x2_c_r[2]    <= x1_prod_r[4] - x1_prod_r[5];
      x2_p_r       <= x1_p_r;
      x2_lk_r      <= x1_lk_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Normalize the cross product into up
  // ---------------------------------------------------------------------------
  logic           n2_v;
  cvm_pkg::word_t up [3];

  cvm_norm #(
    .IW        (64),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_v_r),
    .in_c      (x2_c_r),
    .out_valid (n2_v),
    .out_n     (up)
  );

  cvm_pkg::word_t pb_r [0:NL-1][3];
  cvm_pkg::word_t lb_r [0:NL-1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      pb_r[0] <= x2_p_r;
      lb_r[0] <= x2_lk_r;
      for (int k = 1; k < NL; k++) begin
        pb_r[k] <= pb_r[k-1];
        lb_r[k] <= lb_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Rebuild right as up x look, rounded back to the fixed-point scale
  // ---------------------------------------------------------------------------
  logic               y1_v_r;
  logic signed [63:0] y1_prod_r [6];
  cvm_pkg::word_t     y1_p_r    [3];
  cvm_pkg::word_t     y1_lk_r   [3];
  cvm_pkg::word_t     y1_up_r   [3];
  logic signed [63:0] y_diff    [3];
  logic               y2_v_r;
  cvm_pkg::word_t     y2_rt_r   [3];
  cvm_pkg::word_t     y2_p_r    [3];
  cvm_pkg::word_t     y2_lk_r   [3];
  cvm_pkg::word_t     y2_up_r   [3];

  always_comb begin
    y_diff[0] = y1_prod_r[0] - y1_prod_r[1] + HALF;
    y_diff[1] = y1_prod_r[2] - y1_prod_r[3] + HALF;
    y_diff[2] = y1_prod_r[4] - y1_prod_r[5] + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y1_v_r <= 1'b0;
      y2_v_r <= 1'b0;
    end else if (en) begin
      y1_v_r <= n2_v;
      y2_v_r <= y1_v_r;
    end
    if (en) begin
      y1_prod_r[0] <= up[1] * lb_r[NL-1][2];
      y1_prod_r[1] <= up[2] * lb_r[NL-1][1];
      y1_prod_r[2] <= up[2] * lb_r[NL-1][0];
      y1_prod_r[3] <= up[0] * lb_r[NL-1][2];
      y1_prod_r[4] <= up[0] * lb_r[NL-1][1];
      y1_prod_r[5] <= up[1] * lb_r[NL-1][0];
      y1_p_r       <= pb_r[NL-1];
      y1_lk_r      <= lb_r[NL-1];
      y1_up_r      <= up;
      for (int i = 0; i < 3; i++) begin
        // arithmetic shift floors, giving round half up
        y2_rt_r[i] <= cvm_pkg::word_t'(32'(y_diff[i] >>> FRAC_BITS));
      end
      y2_p_r  <= y1_p_r;
      y2_lk_r <= y1_lk_r;
      y2_up_r <= y1_up_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Translation row: -P.axis, rounded and saturated
  // ---------------------------------------------------------------------------
  logic               z1_v_r;
  logic signed [63:0] z1_prod_r [3][3];
  cvm_pkg::word_t     z1_ax_r   [3][3];
  logic               z2_v_r;
  logic signed [63:0] z2_d_r    [3];
  cvm_pkg::word_t     z2_ax_r   [3][3];
  logic signed [63:0] z_rnd     [3];
  cvm_pkg::word_t     z_sat     [3];
  cvm_pkg::word_t     ax        [3][3];

  // axis order: right, up, look
  always_comb begin
    ax[0] = y2_rt_r;
    ax[1] = y2_up_r;
    ax[2] = y2_lk_r;
    for (int a = 0; a < 3; a++) begin
      z_rnd[a] = (HALF - z2_d_r[a]) >>> FRAC_BITS;
      if (z_rnd[a] > S_MAX) begin
        z_sat[a] = cvm_pkg::word_t'(32'(S_MAX));
      end else if (z_rnd[a] < S_MIN) begin
        z_sat[a] = cvm_pkg::word_t'(32'(S_MIN));
      end else begin
        z_sat[a] = cvm_pkg::word_t'(32'(z_rnd[a]));
      end
    end
  end

  cvm_pkg::word_t o_ax_r [3][3];
  cvm_pkg::word_t o_tr_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_v_r      <= 1'b0;
      z2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      z1_v_r      <= y2_v_r;
      z2_v_r      <= z1_v_r;
      out_valid_r <= z2_v_r;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          z1_prod_r[a][i] <= y2_p_r[i] * ax[a][i];
        end
        z2_d_r[a] <= z1_prod_r[a][0] + z1_prod_r[a][1] + z1_prod_r[a][2];
      end
      z1_ax_r <= ax;
      z2_ax_r <= z1_ax_r;
      o_ax_r  <= z2_ax_r;
      o_tr_r  <= z_sat;
    end
  end

  // Drive the result beat
  assign out_ch.valid   = out_valid_r;
  assign out_ch.right_x = o_ax_r[0][0];
  assign out_ch.right_y = o_ax_r[0][1];
  assign out_ch.right_z = o_ax_r[0][2];
  assign out_ch.up_x    = o_ax_r[1][0];
  assign out_ch.up_y    = o_ax_r[1][1];
  assign out_ch.up_z    = o_ax_r[1][2];
  assign out_ch.look_x  = o_ax_r[2][0];
  assign out_ch.look_y  = o_ax_r[2][1];
  assign out_ch.look_z  = o_ax_r[2][2];
  assign out_ch.trans_x = o_tr_r[0];
  assign out_ch.trans_y = o_tr_r[1];
  assign out_ch.trans_z = o_tr_r[2];

`ifndef SYNTH
  // A normalized look component never exceeds one.
  a_look_unit: assert property (@(posedge clk) disable iff (!rst_n)
    n1_v |-> (lk[0] <= ONE && lk[0] >= -ONE && lk[1] <= ONE && lk[1] >= -ONE &&
              lk[2] <= ONE && lk[2] >= -ONE))
    else $error("look component out of unit range");

  // Same bound on the normalized up axis.
  a_up_unit: assert property (@(posedge clk) disable iff (!rst_n)
    n2_v |-> (up[0] <= ONE && up[0] >= -ONE && up[1] <= ONE && up[1] >= -ONE &&
              up[2] <= ONE && up[2] >= -ONE))
    else $error("up component out of unit range");

  // A zero look axis collapses the whole frame and translation to zero.
  a_zero_look: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_ax_r[2][0] == 0 && o_ax_r[2][1] == 0 && o_ax_r[2][2] == 0) |->
    (o_ax_r[0][0] == 0 && o_ax_r[0][1] == 0 && o_ax_r[0][2] == 0 &&
     o_ax_r[1][0] == 0 && o_ax_r[1][1] == 0 && o_ax_r[1][2] == 0 &&
     o_tr_r[0] == 0 && o_tr_r[1] == 0 && o_tr_r[2] == 0))
    else $error("zero look did not give a zero frame");

  // While the output beat is stuck, the pipeline ahead of it must hold.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(z2_v_r) && $stable(n2_v) && $stable(n1_v)))
    else $error("pipeline advanced during a stall");
`endif

endmodule
